// File: rtl/vertex_transform_bbox_macros.svh
// Assertion helpers shared by the front end, queue and back end.
`ifndef VERTEX_TRANSFORM_BBOX_MACROS_SVH
`define VERTEX_TRANSFORM_BBOX_MACROS_SVH

// Same-cycle implication.
`define VTB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vertex_transform_bbox assertion failed");

// Next-cycle implication.
`define VTB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vertex_transform_bbox assertion failed");

`endif

// File: rtl/vtb_pkg.sv
`timescale 1ns / 1ps
package vtb_pkg;

   localparam int COORD_W     = 32;
   localparam int COEF_W      = 20;
   localparam int FRAC_W      = 16;
   localparam int PROD_W      = COORD_W + COEF_W;
   localparam int ACC_W       = 40;
   localparam int NUM_AXES    = 3;
   localparam int CFG_W       = 60;
   localparam int CSR_INDEX_W = 3;

   localparam int ROW_LENGTH_DEFAULT  = 4;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [CFG_W-1:0] MATRIX_ROW0_RESET = 60'd65536;
   localparam logic [CFG_W-1:0] MATRIX_ROW1_RESET = 60'd68719476736;
   localparam logic [CFG_W-1:0] MATRIX_ROW2_RESET = 60'd72057594037927936;
   localparam logic [CFG_W-1:0] AXIS_SCALES_RESET = 60'd72057662757470208;

   localparam logic signed [ACC_W-1:0] SAT_HI = 40'sd2147483647;
   localparam logic signed [ACC_W-1:0] SAT_LO = -40'sd2147483648;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MATRIX_ROW0 = 3'd0,
      CSR_MATRIX_ROW1 = 3'd1,
      CSR_MATRIX_ROW2 = 3'd2,
      CSR_AXIS_SCALES = 3'd3,
      CSR_OFFSET_X    = 3'd4,
      CSR_OFFSET_Y    = 3'd5,
      CSR_OFFSET_Z    = 3'd6
   } csr_index_type;

   // Transformed vertex handed from the front end to the back end.
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      last;
   } vertex_type;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      if (v > SAT_HI) begin
         return SAT_HI[COORD_W-1:0];
      end else if (v < SAT_LO) begin
         return SAT_LO[COORD_W-1:0];
      end
      return v[COORD_W-1:0];
   endfunction

endpackage

// File: rtl/vtb_req_if.sv
`timescale 1ns / 1ps
interface vtb_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [vtb_pkg::COORD_W-1:0] coord_x;
   logic signed [vtb_pkg::COORD_W-1:0] coord_y;
   logic signed [vtb_pkg::COORD_W-1:0] coord_z;
   logic                               last_vertex;

   modport source (output valid, coord_x, coord_y, coord_z, last_vertex, input ready);
   modport sink (input valid, coord_x, coord_y, coord_z, last_vertex, output ready);
endinterface

// File: rtl/vtb_rsp_if.sv
`timescale 1ns / 1ps
interface vtb_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [vtb_pkg::COORD_W-1:0] out_x;
   logic signed [vtb_pkg::COORD_W-1:0] out_y;
   logic signed [vtb_pkg::COORD_W-1:0] out_z;
   logic                               row_end;
   logic signed [vtb_pkg::COORD_W-1:0] box_max_x;
   logic signed [vtb_pkg::COORD_W-1:0] box_min_y;
   logic signed [vtb_pkg::COORD_W-1:0] box_min_x;
   logic signed [vtb_pkg::COORD_W-1:0] box_max_y;
   logic                               box_found;
   logic                               count_whole;

   modport source (output valid, out_x, out_y, out_z, row_end, box_max_x, box_min_y,
                   box_min_x, box_max_y, box_found, count_whole, input ready);
   modport sink (input valid, out_x, out_y, out_z, row_end, box_max_x, box_min_y,
                 box_min_x, box_max_y, box_found, count_whole, output ready);
endinterface

// File: rtl/vtb_csr_if.sv
`timescale 1ns / 1ps
interface vtb_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [vtb_pkg::CSR_INDEX_W-1:0]      index;
   logic [vtb_pkg::CFG_W-1:0]            data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/vtb_front.sv
`timescale 1ns / 1ps
`include "vertex_transform_bbox_macros.svh"
module vtb_front (
   input  logic                clock,
   input  logic                reset,
   vtb_req_if.sink             req,
   vtb_csr_if.sink             csr,
   output logic                push_valid,
   input  logic                push_ready,
   output vtb_pkg::vertex_type push_item
);

   localparam int CW = vtb_pkg::COORD_W;
   localparam int EW = vtb_pkg::COEF_W;
   localparam int PW = vtb_pkg::PROD_W;
   localparam int AW = vtb_pkg::ACC_W;
   localparam int NA = vtb_pkg::NUM_AXES;
   localparam int FW = vtb_pkg::FRAC_W;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCALE  = 5'b00010,
      ST_MATRIX = 5'b00100,
      ST_SUM    = 5'b01000,
      ST_PUSH   = 5'b10000
   } fe_state_type;

   fe_state_type state_ff, state_in;

   logic [vtb_pkg::CFG_W-1:0] row_ff [NA];
   logic [vtb_pkg::CFG_W-1:0] row_in [NA];
   logic [vtb_pkg::CFG_W-1:0] scales_ff, scales_in;
   logic signed [CW-1:0]      offset_ff [NA];
   logic signed [CW-1:0]      offset_in [NA];

   logic signed [CW-1:0] coord_ff [NA];
   logic signed [CW-1:0] coord_in [NA];
   logic                 last_ff, last_in;
   logic signed [PW-1:0] sprod_ff [NA];
   logic signed [PW-1:0] sprod_in [NA];
   logic signed [PW-1:0] mprod_ff [NA][NA];
   logic signed [PW-1:0] mprod_in [NA][NA];
   logic signed [CW-1:0] res_ff [NA];
   logic signed [CW-1:0] res_in [NA];

   logic signed [CW-1:0] scaled [NA];
   logic signed [AW-1:0] acc [NA];
   logic                 accept;

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;

   assign push_valid     = (state_ff == ST_PUSH);
   assign push_item.x    = res_ff[0];
   assign push_item.y    = res_ff[1];
   assign push_item.z    = res_ff[2];
   assign push_item.last = last_ff;

   // Register writes
   always_comb begin
      row_in    = row_ff;
      scales_in = scales_ff;
      offset_in = offset_ff;
      if (csr.valid) begin
         unique case (vtb_pkg::csr_index_type'(csr.index))
            vtb_pkg::CSR_MATRIX_ROW0: row_in[0] = csr.data;
            vtb_pkg::CSR_MATRIX_ROW1: row_in[1] = csr.data;
            vtb_pkg::CSR_MATRIX_ROW2: row_in[2] = csr.data;
            vtb_pkg::CSR_AXIS_SCALES: scales_in = csr.data;
            vtb_pkg::CSR_OFFSET_X:    offset_in[0] = csr.data[CW-1:0];
            vtb_pkg::CSR_OFFSET_Y:    offset_in[1] = csr.data[CW-1:0];
            vtb_pkg::CSR_OFFSET_Z:    offset_in[2] = csr.data[CW-1:0];
            default: ;
         endcase
      end
   end

   // Datapath: scale products, matrix products, sum and saturate
   always_comb begin
      coord_in = coord_ff;
      last_in  = last_ff;
      if (accept) begin
         coord_in[0] = req.coord_x;
         coord_in[1] = req.coord_y;
         coord_in[2] = req.coord_z;
         last_in     = req.last_vertex;
      end
      for (int a = 0; a < NA; a++) begin
         sprod_in[a] = PW'(coord_ff[a]) * PW'($signed(scales_ff[a*EW +: EW]));
         scaled[a]   = vtb_pkg::sat32(AW'(sprod_ff[a] >>> FW));
      end
      for (int r = 0; r < NA; r++) begin
         acc[r] = AW'(offset_ff[r]);
         for (int c = 0; c < NA; c++) begin
            mprod_in[r][c] = PW'($signed(row_ff[r][c*EW +: EW])) * PW'(scaled[c]);
            acc[r]         = acc[r] + AW'(mprod_ff[r][c] >>> FW);
         end
         res_in[r] = vtb_pkg::sat32(acc[r]);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_MATRIX;
         ST_MATRIX: state_in = ST_SUM;
         ST_SUM:    state_in = ST_PUSH;
         ST_PUSH:   if (push_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff[0]    <= vtb_pkg::MATRIX_ROW0_RESET;
         row_ff[1]    <= vtb_pkg::MATRIX_ROW1_RESET;
         row_ff[2]    <= vtb_pkg::MATRIX_ROW2_RESET;
         scales_ff    <= vtb_pkg::AXIS_SCALES_RESET;
         offset_ff[0] <= '0;
         offset_ff[1] <= '0;
         offset_ff[2] <= '0;
      end else begin
         state_ff  <= state_in;
         row_ff    <= row_in;
         scales_ff <= scales_in;
         offset_ff <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      coord_ff <= coord_in;
      last_ff  <= last_in;
      if (state_ff == ST_SCALE) begin
         sprod_ff <= sprod_in;
      end
      if (state_ff == ST_MATRIX) begin
         mprod_ff <= mprod_in;
      end
      if (state_ff == ST_SUM) begin
         res_ff <= res_in;
      end
   end

   `VTB_ASSERT_IMP(a_accept_reaches_push, clock, reset, accept, ##4 (state_ff == ST_PUSH))

endmodule

// File: rtl/vtb_queue.sv
`timescale 1ns / 1ps
`include "vertex_transform_bbox_macros.svh"
module vtb_queue #(
   parameter int DEPTH = vtb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  vtb_pkg::vertex_type push_item,
   output logic                pop_valid,
   input  logic                pop_ready,
   output vtb_pkg::vertex_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   vtb_pkg::vertex_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push_fire, pop_fire;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `VTB_ASSERT_NXT(a_push_grows, clock, reset, push_fire && !pop_fire, count_ff == $past(count_ff) + 1'b1)
   `VTB_ASSERT_NXT(a_pop_shrinks, clock, reset, pop_fire && !push_fire, count_ff == $past(count_ff) - 1'b1)

endmodule

// File: rtl/vtb_back.sv
`timescale 1ns / 1ps
`include "vertex_transform_bbox_macros.svh"
module vtb_back #(
   parameter int ROW_LENGTH = vtb_pkg::ROW_LENGTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  vtb_pkg::vertex_type pop_item,
   vtb_rsp_if.source           rsp
);

   localparam int CW    = vtb_pkg::COORD_W;
   localparam int ROW_W = (ROW_LENGTH > 1) ? $clog2(ROW_LENGTH) : 1;

   logic signed [CW-1:0] max_x_ff, max_x_in, min_x_ff, min_x_in;
   logic signed [CW-1:0] max_y_ff, max_y_in, min_y_ff, min_y_in;
   logic                 seen_ff, seen_in;
   logic [ROW_W-1:0]     row_ff, row_in;

   logic signed [CW-1:0] upd_max_x, upd_min_x, upd_max_y, upd_min_y;
   logic                 upd_seen, z_zero, row_end, pop_fire, box_out;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [CW-1:0] o_x_ff, o_y_ff, o_z_ff;
   logic signed [CW-1:0] o_max_x_ff, o_min_y_ff, o_min_x_ff, o_max_y_ff;
   logic                 o_row_end_ff, o_found_ff, o_whole_ff;

   assign pop_ready = !rsp_valid_ff || rsp.ready;
   assign pop_fire  = pop_valid && pop_ready;

   always_comb begin
      z_zero    = (pop_item.z == '0);
      upd_max_x = max_x_ff;
      upd_min_x = min_x_ff;
      upd_max_y = max_y_ff;
      upd_min_y = min_y_ff;
      upd_seen  = seen_ff || z_zero;
      if (z_zero) begin
         if (!seen_ff || pop_item.x > max_x_ff) upd_max_x = pop_item.x;
         if (!seen_ff || pop_item.x < min_x_ff) upd_min_x = pop_item.x;
         if (!seen_ff || pop_item.y > max_y_ff) upd_max_y = pop_item.y;
         if (!seen_ff || pop_item.y < min_y_ff) upd_min_y = pop_item.y;
      end
      row_end = (row_ff == ROW_W'(ROW_LENGTH - 1));
      box_out = pop_item.last && upd_seen;

      max_x_in = max_x_ff;
      min_x_in = min_x_ff;
      max_y_in = max_y_ff;
      min_y_in = min_y_ff;
      seen_in  = seen_ff;
      row_in   = row_ff;
      if (pop_fire) begin
         // Drop the object's state after its last vertex.
         if (pop_item.last) begin
            max_x_in = '0;
            min_x_in = '0;
            max_y_in = '0;
            min_y_in = '0;
            seen_in  = 1'b0;
            row_in   = '0;
         end else begin
            max_x_in = upd_max_x;
            min_x_in = upd_min_x;
            max_y_in = upd_max_y;
            min_y_in = upd_min_y;
            seen_in  = upd_seen;
            row_in   = row_end ? '0 : row_ff + 1'b1;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (pop_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_x_ff     <= '0;
         min_x_ff     <= '0;
         max_y_ff     <= '0;
         min_y_ff     <= '0;
         seen_ff      <= 1'b0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_x_ff     <= max_x_in;
         min_x_ff     <= min_x_in;
         max_y_ff     <= max_y_in;
         min_y_ff     <= min_y_in;
         seen_ff      <= seen_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         o_x_ff       <= pop_item.x;
         o_y_ff       <= pop_item.y;
         o_z_ff       <= pop_item.z;
         o_row_end_ff <= row_end;
         o_max_x_ff   <= box_out ? upd_max_x : '0;
         o_min_y_ff   <= box_out ? upd_min_y : '0;
         o_min_x_ff   <= box_out ? upd_min_x : '0;
         o_max_y_ff   <= box_out ? upd_max_y : '0;
         o_found_ff   <= box_out;
         o_whole_ff   <= pop_item.last && row_end;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_x       = o_x_ff;
   assign rsp.out_y       = o_y_ff;
   assign rsp.out_z       = o_z_ff;
   assign rsp.row_end     = o_row_end_ff;
   assign rsp.box_max_x   = o_max_x_ff;
   assign rsp.box_min_y   = o_min_y_ff;
   assign rsp.box_min_x   = o_min_x_ff;
   assign rsp.box_max_y   = o_max_y_ff;
   assign rsp.box_found   = o_found_ff;
   assign rsp.count_whole = o_whole_ff;

   `VTB_ASSERT_NXT(a_last_clears, clock, reset, pop_fire && pop_item.last, !seen_ff && row_ff == '0)
   `VTB_ASSERT_IMP(a_box_ordered, clock, reset, rsp_valid_ff && o_found_ff, o_max_x_ff >= o_min_x_ff && o_max_y_ff >= o_min_y_ff)
   `VTB_ASSERT_IMP(a_whole_on_row_end, clock, reset, rsp_valid_ff && o_whole_ff, o_row_end_ff)

endmodule

// File: rtl/vertex_transform_bbox.sv
`timescale 1ns / 1ps
// Each vertex passes the scale, matrix, sum/saturate, queue and output registers in turn.
// The front end works one vertex at a time and takes no new one until the last is pushed:
//   accept, scale, matrix, sum/saturate, and a push that stalls on a full queue.
// The 2-entry queue and the output register let the front end run ahead while results stall.
// Reset (synchronous, active high): registers return to the identity transform, the box
//   and row count clear, and the queue and output register empty.
module vertex_transform_bbox #(
   parameter int ROW_LENGTH  = vtb_pkg::ROW_LENGTH_DEFAULT,
   parameter int QUEUE_DEPTH = vtb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   vtb_req_if.sink     req_ch,
   vtb_rsp_if.source   rsp_ch,
   vtb_csr_if.sink     csr_ch
);

   // Front end to queue
   logic                push_valid;
   logic                push_ready;
   vtb_pkg::vertex_type push_item;

   // Queue to back end
   logic                pop_valid;
   logic                pop_ready;
   vtb_pkg::vertex_type pop_item;

   // Front end: hold the configuration registers, accept a vertex, scale each axis,
   // rotate, translate and saturate, then transfer the result into the queue.
   vtb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .csr        (csr_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // Short queue: decouple the transform from a stalled result channel.
   vtb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Back end: advance the row counter, track the box over z == 0 vertices,
   // report it on the last vertex of an object and hold the result until transfer.
   vtb_back #(
      .ROW_LENGTH (ROW_LENGTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp       (rsp_ch)
   );

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import vtb_pkg::*;

   localparam int CLOCK_PERIOD = 4;
   localparam int RESET_CYCLES = 10;
   localparam int DRAIN_CYCLES = 16;    // well past the input-to-result latency
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills queue and pipeline
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int PHASE_ITEMS  = 345;
   localparam int GROUP_LEN    = ROW_LENGTH_DEFAULT;

   localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;

   localparam logic [COEF_W-1:0] COEF_ZERO    = 20'h00000;
   localparam logic [COEF_W-1:0] COEF_ONE     = 20'h10000;
   localparam logic [COEF_W-1:0] COEF_NEG_ONE = 20'hF0000;
   localparam logic [COEF_W-1:0] COEF_MAX     = 20'h7FFFF;
   localparam logic [COEF_W-1:0] COEF_MIN     = 20'h80000;

   // Index past the register map; writes to it must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_UNUSED = 3'd7;

   typedef enum {SETUP_DEPTH_Z, SETUP_EXTREME, SETUP_RANDOM} setup_kind_type;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      last;
   } vertex_stim_type;

   typedef struct {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic                      row_end;
      logic signed [COORD_W-1:0] box_max_x;
      logic signed [COORD_W-1:0] box_min_y;
      logic signed [COORD_W-1:0] box_min_x;
      logic signed [COORD_W-1:0] box_max_y;
      logic                      box_found;
      logic                      count_whole;
   } vertex_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vtb_req_if req_ch ();
   vtb_rsp_if rsp_ch ();
   vtb_csr_if csr_ch ();

   vertex_transform_bbox u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Vertices waiting to be offered, and transformed vertices waiting to come back.
   vertex_stim_type   vertex_queue[$];
   vertex_result_type expected_vertices[$];

   int mismatch_count     = 0;
   int results_seen       = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int holds_asked        = 0;
   int holds_done;
   int hold_left;

   // Transform settings as the block should hold them.
   logic [CFG_W-1:0]          matrix_rows [3];
   logic [CFG_W-1:0]          scale_word;
   logic signed [COORD_W-1:0] offsets [3];

   // Running box over the z==0 vertices of the current object.
   logic signed [COORD_W-1:0] box_hi_x, box_lo_y, box_lo_x, box_hi_y;
   logic                      box_seen;
   int                        group_count;

   // ------------------------------------------------------------------
   // Fixed-point helpers
   // ------------------------------------------------------------------

   // Pull one signed Q4.16 factor out of a packed 60-bit word.
   function automatic logic signed [63:0] q4_factor(logic [CFG_W-1:0] word, int slot);
      logic signed [COEF_W-1:0] c;
      c = word[slot*COEF_W +: COEF_W];
      return 64'(c);
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_q16(logic signed [63:0] v);
      if (v > Q_MAX) begin
         return Q_MAX;
      end else if (v < Q_MIN) begin
         return Q_MIN;
      end
      return v[COORD_W-1:0];
   endfunction

   function automatic logic [CFG_W-1:0] pack3(logic [COEF_W-1:0] c0, logic [COEF_W-1:0] c1,
                                              logic [COEF_W-1:0] c2);
      return {c2, c1, c0};
   endfunction

   // Scale, rotate, translate and saturate one vertex; advance the box and
   // group count. Products drop 16 fraction bits by arithmetic shift, which
   // rounds toward minus infinity.
   function automatic vertex_result_type transform_vertex(vertex_stim_type v);
      logic signed [63:0]        coord [3];
      logic signed [63:0]        scaled [3];
      logic signed [63:0]        prod;
      logic signed [63:0]        acc;
      logic signed [COORD_W-1:0] pos [3];
      vertex_result_type         r;
      int                        ia;
      int                        ic;
      coord[0] = 64'(v.x);
      coord[1] = 64'(v.y);
      coord[2] = 64'(v.z);
      for (ia = 0; ia < NUM_AXES; ia++) begin
         prod = coord[ia] * q4_factor(scale_word, ia);
         scaled[ia] = 64'(clamp_q16(prod >>> FRAC_W));
      end
      // Sum is exact; saturate once at the end of each row.
      for (ia = 0; ia < NUM_AXES; ia++) begin
         acc = 64'(offsets[ia]);
         for (ic = 0; ic < NUM_AXES; ic++) begin
            prod = q4_factor(matrix_rows[ia], ic) * scaled[ic];
            acc  = acc + (prod >>> FRAC_W);
         end
         pos[ia] = clamp_q16(acc);
      end

      // Track the box only on saturated z exactly zero; first hit seeds it.
      if (pos[2] == 0) begin
         if (!box_seen) begin
            box_hi_x = pos[0];
            box_lo_x = pos[0];
            box_hi_y = pos[1];
            box_lo_y = pos[1];
            box_seen = 1'b1;
         end else begin
            if (pos[0] > box_hi_x) box_hi_x = pos[0];
            if (pos[0] < box_lo_x) box_lo_x = pos[0];
            if (pos[1] > box_hi_y) box_hi_y = pos[1];
            if (pos[1] < box_lo_y) box_lo_y = pos[1];
         end
      end

      group_count++;
      r.row_end = (group_count >= GROUP_LEN);
      if (r.row_end) group_count = 0;

      r.out_x       = pos[0];
      r.out_y       = pos[1];
      r.out_z       = pos[2];
      r.box_max_x   = '0;
      r.box_min_y   = '0;
      r.box_min_x   = '0;
      r.box_max_y   = '0;
      r.box_found   = 1'b0;
      r.count_whole = 1'b0;

      // Report the box on the last vertex, then clear the object state.
      if (v.last) begin
         if (box_seen) begin
            r.box_max_x = box_hi_x;
            r.box_min_y = box_lo_y;
            r.box_min_x = box_lo_x;
            r.box_max_y = box_hi_y;
            r.box_found = 1'b1;
         end
         r.count_whole = (group_count == 0);
         box_hi_x    = '0;
         box_lo_y    = '0;
         box_lo_x    = '0;
         box_hi_y    = '0;
         box_seen    = 1'b0;
         group_count = 0;
      end
      return r;
   endfunction

   // Mirror one register write; unknown indexes drop out.
   function automatic void apply_register(logic [CSR_INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
         CSR_MATRIX_ROW0: matrix_rows[0] = data;
         CSR_MATRIX_ROW1: matrix_rows[1] = data;
         CSR_MATRIX_ROW2: matrix_rows[2] = data;
         CSR_AXIS_SCALES: scale_word     = data;
         CSR_OFFSET_X:    offsets[0]     = data[COORD_W-1:0];
         CSR_OFFSET_Y:    offsets[1]     = data[COORD_W-1:0];
         CSR_OFFSET_Z:    offsets[2]     = data[COORD_W-1:0];
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   // Count every mismatch and print one line for it.
   task automatic flag_mismatch(string msg);
      mismatch_count++;
      $display("mismatch: %s", msg);
   endtask

   task automatic check_field(string name, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
      if (got !== want) begin
         flag_mismatch($sformatf("vertex %0d %s got %h want %h", results_seen, name, got, want));
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Mix extremes, small values near zero and full-range noise.
   function automatic logic signed [COORD_W-1:0] pick_coord();
      logic signed [COORD_W-1:0] v;
      case ($urandom_range(9))
         0: v = Q_MAX;
         1: v = Q_MIN;
         2: v = ($urandom_range(1) == 0) ? 32'sd0 : -32'sd1;
         3, 4, 5: v = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
         default: v = $urandom();
      endcase
      return v;
   endfunction

   function automatic logic [COEF_W-1:0] random_coef();
      logic [COEF_W-1:0] c;
      case ($urandom_range(4))
         0: c = COEF_W'($urandom());
         1: c = COEF_ONE;
         2: c = COEF_NEG_ONE;
         3: c = COEF_W'($urandom_range(0, 20'h3FFFF) - 20'h20000);  // within +/-2.0
         default: c = COEF_ZERO;
      endcase
      return c;
   endfunction

   task automatic push_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              logic signed [COORD_W-1:0] z, logic last);
      vertex_stim_type v;
      v.x    = x;
      v.y    = y;
      v.z    = z;
      v.last = last;
      vertex_queue.push_back(v);
   endtask

   // Queue whole objects of random length. With aim_zero, half the vertices
   // cancel offset_z so the box gets real traffic; a few last flags are noise.
   task automatic queue_objects(int count, bit aim_zero);
      int queued;
      int len;
      int k;
      logic last;
      logic signed [COORD_W-1:0] z;
      queued = 0;
      while (queued < count) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
         for (k = 0; k < len; k++) begin
            last = (k == len - 1);
            if ($urandom_range(15) == 0) last = 1'($urandom_range(1));
            if (aim_zero && $urandom_range(1) == 1) begin
               z = -offsets[2];
            end else begin
               z = pick_coord();
            end
            push_vertex(pick_coord(), pick_coord(), z, last);
            queued++;
         end
      end
   endtask

   // One transfer on the register port; mirror it at the transfer edge.
   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      apply_register(idx, data);
      csr_ch.valid <= 1'b0;
   endtask

   // Write all seven registers for the next phase.
   task automatic load_setup(setup_kind_type kind);
      logic [CFG_W-1:0] r0, r1, r2, sc, ox, oy, oz;
      case (kind)
         SETUP_DEPTH_Z: begin
            // z passes straight through, so coord_z == -offset_z lands on z == 0.
            r0 = pack3(random_coef(), random_coef(), random_coef());
            r1 = pack3(random_coef(), random_coef(), random_coef());
            r2 = pack3(COEF_ZERO, COEF_ZERO, COEF_ONE);
            sc = pack3(random_coef(), random_coef(), COEF_ONE);
            ox = {28'd0, pick_coord()};
            oy = {28'd0, pick_coord()};
            oz = {28'd0, pick_coord()};
         end
         SETUP_EXTREME: begin
            // Largest factors and offsets: saturation everywhere, z always zero.
            r0 = pack3(COEF_MAX, COEF_MAX, COEF_MAX);
            r1 = pack3(COEF_MIN, COEF_MIN, COEF_MIN);
            r2 = pack3(COEF_ZERO, COEF_ZERO, COEF_ZERO);
            sc = pack3(COEF_MAX, COEF_MIN, COEF_MAX);
            ox = {28'd0, Q_MAX};
            oy = {28'd0, Q_MIN};
            oz = '0;
         end
         default: begin
            // Raw noise, including bits above the offset width.
            r0 = CFG_W'({$urandom(), $urandom()});
            r1 = CFG_W'({$urandom(), $urandom()});
            r2 = CFG_W'({$urandom(), $urandom()});
            sc = CFG_W'({$urandom(), $urandom()});
            ox = CFG_W'({$urandom(), $urandom()});
            oy = CFG_W'({$urandom(), $urandom()});
            oz = CFG_W'({$urandom(), $urandom()});
         end
      endcase
      write_register(CSR_MATRIX_ROW0, r0);
      write_register(CSR_MATRIX_ROW1, r1);
      write_register(CSR_MATRIX_ROW2, r2);
      write_register(CSR_AXIS_SCALES, sc);
      write_register(CSR_OFFSET_X, ox);
      write_register(CSR_OFFSET_Y, oy);
      write_register(CSR_OFFSET_Z, oz);
      @(negedge clock);
   endtask

   // Block until every queued vertex is sent and every result is back.
   task automatic wait_for_drain();
      do @(negedge clock);
      while (vertex_queue.size() != 0 || req_ch.valid || expected_vertices.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Sender: offer queued vertices, idling at random; predict on each transfer.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : sender
      vertex_stim_type next_vertex;
      vertex_stim_type taken;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            taken.x    = req_ch.coord_x;
            taken.y    = req_ch.coord_y;
            taken.z    = req_ch.coord_z;
            taken.last = req_ch.last_vertex;
            expected_vertices.push_back(transform_vertex(taken));
         end
         // Hold a pending offer until it transfers; otherwise pick the next one.
         if (!req_ch.valid || req_ch.ready) begin
            if (vertex_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_vertex = vertex_queue.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.coord_x     <= next_vertex.x;
               req_ch.coord_y     <= next_vertex.y;
               req_ch.coord_z     <= next_vertex.z;
               req_ch.last_vertex <= next_vertex.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: stall at random, and drop ready for a whole hold-off stretch.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : hold_off
      if (reset) begin
         hold_left  <= 0;
         holds_done <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         hold_left  <= HOLD_CYCLES;
         holds_done <= holds_asked;
      end
   end

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: compare each result transfer with the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      vertex_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_vertices.size() == 0) begin
            flag_mismatch($sformatf("vertex %0d arrived with none pending", results_seen));
         end else begin
            want = expected_vertices.pop_front();
            check_field("out_x", rsp_ch.out_x, want.out_x);
            check_field("out_y", rsp_ch.out_y, want.out_y);
            check_field("out_z", rsp_ch.out_z, want.out_z);
            check_field("row_end", rsp_ch.row_end, want.row_end);
            check_field("box_max_x", rsp_ch.box_max_x, want.box_max_x);
            check_field("box_min_y", rsp_ch.box_min_y, want.box_min_y);
            check_field("box_min_x", rsp_ch.box_min_x, want.box_min_x);
            check_field("box_max_y", rsp_ch.box_max_y, want.box_max_y);
            check_field("box_found", rsp_ch.box_found, want.box_found);
            check_field("count_whole", rsp_ch.count_whole, want.count_whole);
         end
         results_seen++;
      end
   end

   // ------------------------------------------------------------------
   // Phases
   // ------------------------------------------------------------------
   initial begin : stimulus
      // Start every input at a known value.
      req_ch.valid       = 1'b0;
      req_ch.coord_x     = '0;
      req_ch.coord_y     = '0;
      req_ch.coord_z     = '0;
      req_ch.last_vertex = 1'b0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = '0;
      csr_ch.data        = '0;

      // Predicted state after reset: identity transform, empty box.
      matrix_rows[0] = MATRIX_ROW0_RESET;
      matrix_rows[1] = MATRIX_ROW1_RESET;
      matrix_rows[2] = MATRIX_ROW2_RESET;
      scale_word     = AXIS_SCALES_RESET;
      offsets[0]     = '0;
      offsets[1]     = '0;
      offsets[2]     = '0;
      box_hi_x       = '0;
      box_lo_y       = '0;
      box_lo_x       = '0;
      box_hi_y       = '0;
      box_seen       = 1'b0;
      group_count    = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed objects under the reset transform (output equals input).
      // Full-range corners on z==0 vertices, one whole group of four.
      push_vertex(0, 0, 0, 1'b0);
      push_vertex(Q_MAX, Q_MIN, 0, 1'b0);
      push_vertex(Q_MIN, Q_MAX, 0, 1'b0);
      push_vertex(-1, 1, 5, 1'b1);
      // Object with no z==0 vertex: box stays unreported.
      push_vertex(1, 2, 3, 1'b0);
      push_vertex(Q_MAX, Q_MAX, Q_MAX, 1'b0);
      push_vertex(Q_MIN, Q_MIN, Q_MIN, 1'b1);
      // Single-vertex objects, with and without a box hit.
      push_vertex(100, -200, 0, 1'b1);
      push_vertex(-5, -6, -7, 1'b1);
      // Five vertices: group end mid-object, count not whole.
      push_vertex(-300, 40, 0, 1'b0);
      push_vertex(-100, -40, -1, 1'b0);
      push_vertex(-700, 90, 0, 1'b0);
      push_vertex(-50, -95, 0, 1'b0);
      push_vertex(12, 7, 1, 1'b1);
      // Eight vertices: two group ends, count whole.
      push_vertex(1, 1, 0, 1'b0);
      push_vertex(2, -2, 9, 1'b0);
      push_vertex(-3, 3, 0, 1'b0);
      push_vertex(4, -4, -9, 1'b0);
      push_vertex(Q_MAX, 0, 0, 1'b0);
      push_vertex(0, Q_MIN, 2, 1'b0);
      push_vertex(-8, 8, 0, 1'b0);
      push_vertex(5, 5, 0, 1'b1);
      // Two-vertex object with whole-unit coordinates.
      push_vertex(32'sh0001_0000, -32'sh0001_0000, 0, 1'b0);
      push_vertex(-32'sh0001_0000, 32'sh0001_0000, 0, 1'b1);
      wait_for_drain();

      // Random transform with z passed through; full rate, plus a long hold-off
      // while the sender keeps offering. Poke the unused index once too.
      load_setup(SETUP_DEPTH_Z);
      write_register(CSR_INDEX_UNUSED, '1);
      @(negedge clock);
      holds_asked++;
      queue_objects(PHASE_ITEMS, 1'b1);
      wait_for_drain();

      // Extreme factors and offsets; sender idles most cycles.
      load_setup(SETUP_EXTREME);
      sender_idle_pct = 64;
      queue_objects(PHASE_ITEMS, 1'b0);
      wait_for_drain();

      // Raw random registers; receiver stalls most cycles.
      load_setup(SETUP_RANDOM);
      sender_idle_pct    = 0;
      receiver_stall_pct = 64;
      queue_objects(PHASE_ITEMS, 1'b0);
      wait_for_drain();

      // Pass-through z again with light idling on both sides and a hold-off.
      load_setup(SETUP_DEPTH_Z);
      sender_idle_pct    = 13;
      receiver_stall_pct = 13;
      holds_asked++;
      queue_objects(PHASE_ITEMS, 1'b1);
      wait_for_drain();

      if (mismatch_count == 0) begin
         $display("[vertex_transform_bbox] OK");
      end else begin
         $display("[vertex_transform_bbox] ERROR");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("[vertex_transform_bbox] ERROR");
      $finish;
   end

endmodule
